[hw/rtl/dcta_pkg.sv]
`default_nettype none
package dcta_pkg;

  localparam int MASS_W = 23;
  localparam int MOM_W  = 24;
  localparam int ID_W   = 16;
  localparam int COS_W  = 16;
  localparam int TOT_W  = 32;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int OPW  = 25;  // operand width of the serial multipliers
  localparam int ROOTW = 24; // root width of the serial square roots
  localparam int QW   = 15;  // quotient bits

  localparam logic signed [ID_W-1:0] ID_LIMIT = 16'sd14;
  localparam logic [QW-1:0]          COS_MAX  = 15'h7FFF;
  localparam logic [MASS_W-1:0]      MASS_LOW_RST  = 23'd38400;
  localparam logic [MASS_W-1:0]      MASS_HIGH_RST = 23'd51200;

  typedef enum logic [0:0] {
    REG_MASS_LOW  = 1'b0,
    REG_MASS_HIGH = 1'b1
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_M2   = 8'b0000_0100,
    ST_SQRT = 8'b0000_1000,
    ST_DEN  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_DONE = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/dcta_if.sv]
`default_nettype none
interface dcta_in_if;
  import dcta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MASS_W-1:0]        plus_energy;
  logic signed [MOM_W-1:0]  plus_px;
  logic signed [MOM_W-1:0]  plus_py;
  logic signed [MOM_W-1:0]  plus_pz;
  logic [MASS_W-1:0]        minus_energy;
  logic signed [MOM_W-1:0]  minus_px;
  logic signed [MOM_W-1:0]  minus_py;
  logic signed [MOM_W-1:0]  minus_pz;
  logic signed [ID_W-1:0]   first_id;
  logic signed [ID_W-1:0]   second_id;

  modport source (output valid, plus_energy, plus_px, plus_py, plus_pz, minus_energy,
                  minus_px, minus_py, minus_pz, first_id, second_id, input ready);
  modport sink   (input valid, plus_energy, plus_px, plus_py, plus_pz, minus_energy,
                  minus_px, minus_py, minus_pz, first_id, second_id, output ready);
endinterface

interface dcta_out_if;
  import dcta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     selected;
  logic [MASS_W-1:0]        pair_mass;
  logic signed [COS_W-1:0]  cos_theta;
  logic                     forward;
  logic [TOT_W-1:0]         selected_total;
  logic [TOT_W-1:0]         forward_total;
  logic [TOT_W-1:0]         backward_total;

  modport source (output valid, selected, pair_mass, cos_theta, forward, selected_total,
                  forward_total, backward_total, input ready);
  modport sink   (input valid, selected, pair_mass, cos_theta, forward, selected_total,
                  forward_total, backward_total, output ready);
endinterface
`default_nettype wire

[hw/rtl/dcta_mul.sv]
`default_nettype none
module dcta_mul #(
  parameter int W = 25
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic      [2*W-1:0] prod_o,
  output logic                busy_o
);
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0]   mc_q, mp_q;
  logic [CW-1:0]  cnt_q;
  logic [W:0]     sum;

  // shift-add, one multiplier bit per cycle
  assign sum   = {1'b0, acc_q[2*W-1:W]} + (mp_q[0] ? {1'b0, mc_q} : '0);
  assign acc_d = {sum, acc_q[W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= a_i;
      mp_q  <= b_i;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      mp_q  <= {1'b0, mp_q[W-1:1]};
    end
  end

  assign prod_o = acc_q;
  assign busy_o = (cnt_q != '0);
endmodule
`default_nettype wire

[hw/rtl/dcta_sqrt.sv]
`default_nettype none
module dcta_sqrt #(
  parameter int W = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [2*W-1:0] rad_i,
  output logic      [W-1:0]   root_o,
  output logic                busy_o
);
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] rad_q;
  logic [W:0]     rem_q;
  logic [W-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic [W+2:0]   r2, trial, diff;
  logic           ge;

  // restoring square root, one root bit per cycle
  assign r2    = {rem_q, rad_q[2*W-1:2*W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = (r2 >= trial);
  assign diff  = r2 - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[2*W-3:0], 2'b00};
      rem_q  <= ge ? diff[W:0] : r2[W:0];
      root_q <= {root_q[W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign busy_o = (cnt_q != '0);
endmodule
`default_nettype wire

[hw/rtl/dilepton_cos_theta_afb_counter_unit.sv]
// channel | dir | handshake        | beat
// evt_i   | in  | valid/ready      | two lepton four-vectors and ids
// res_o   | out | valid/ready      | selection, mass, cosine, totals
// apb     | in  | psel/penable     | mass_low at 0x0, mass_high at 0x4
//
// The time an event takes is set by the bit-serial multipliers (unit 0 is
// used twice when the event is selected), the square roots and the 15-step
// divider. A finished beat sits in the output register, so the next event
// is taken while it waits. Reset clears the counters and loads the default
// mass window.
`default_nettype none
module dilepton_cos_theta_afb_counter_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dcta_in_if.sink                            evt_i,
  dcta_out_if.source                         res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dcta_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dcta_pkg::DATA_W-1:0]   pwdata,
  output logic      [dcta_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import dcta_pkg::*;

  localparam int NMUL = 6;

  state_e state_q, state_d;

  logic [MASS_W-1:0] mass_low_q, mass_high_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  // event operands
  logic              accept;
  logic [OPW-1:0]    e_sum, px_abs, py_abs, pz_abs, mpz_abs, ppz_abs;
  logic [OPW-1:0]    px_sum, py_sum, pz_sum;
  logic              pz_neg_q, s1_q, s2_q, ids_ok_q;

  logic [OPW-1:0]    mul_a [NMUL];
  logic [OPW-1:0]    mul_b [NMUL];
  logic [2*OPW-1:0]  prod  [NMUL];
  logic [NMUL-1:0]   mul_busy;
  logic              mul0_start, mul_rest_start;

  logic signed [2*OPW:0] t_q, qt2_q, m2;
  logic signed [48:0]    d_q, sp1, sp2;
  logic [47:0]           dmag, mag_q, den_q, rem_q;
  logic                  d_pos_q, m2_neg_q;

  logic              sq_start;
  logic [ROOTW-1:0]  root_a, root_b;
  logic              sqa_busy, sqb_busy;

  logic              sel_now, sel_q;
  logic [ROOTW-1:0]  mass_q;
  logic [QW-1:0]     q_q;
  logic [3:0]        div_cnt_q;
  logic [48:0]       rem2;
  logic              rem_ge;

  logic              neg;
  logic              fwd;
  logic [COS_W-1:0]  cos_val;
  logic              out_load;

  logic [COUNT_WIDTH-1:0] sel_cnt_q, fwd_cnt_q, bwd_cnt_q;
  logic [COUNT_WIDTH-1:0] sel_cnt_d, fwd_cnt_d, bwd_cnt_d;

  logic              ov_q;
  logic              o_sel_q, o_fwd_q;
  logic [MASS_W-1:0] o_mass_q;
  logic [COS_W-1:0]  o_cos_q;
  logic [TOT_W-1:0]  o_st_q, o_ft_q, o_bt_q;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign prdata  = (cfg_idx == REG_MASS_HIGH) ? DATA_W'(mass_high_q) : DATA_W'(mass_low_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_low_q  <= MASS_LOW_RST;
      mass_high_q <= MASS_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MASS_LOW:  mass_low_q  <= pwdata[MASS_W-1:0];
        REG_MASS_HIGH: mass_high_q <= pwdata[MASS_W-1:0];
        default: ;
      endcase
    end
  end

  // input operands
  assign evt_i.ready = (state_q == ST_IDLE);
  assign accept      = evt_i.valid && evt_i.ready;

  assign e_sum  = {2'b00, evt_i.plus_energy} + {2'b00, evt_i.minus_energy};
  assign px_sum = {evt_i.plus_px[MOM_W-1], evt_i.plus_px}
                + {evt_i.minus_px[MOM_W-1], evt_i.minus_px};
  assign py_sum = {evt_i.plus_py[MOM_W-1], evt_i.plus_py}
                + {evt_i.minus_py[MOM_W-1], evt_i.minus_py};
  assign pz_sum = {evt_i.plus_pz[MOM_W-1], evt_i.plus_pz}
                + {evt_i.minus_pz[MOM_W-1], evt_i.minus_pz};
  assign px_abs = px_sum[OPW-1] ? -px_sum : px_sum;
  assign py_abs = py_sum[OPW-1] ? -py_sum : py_sum;
  assign pz_abs = pz_sum[OPW-1] ? -pz_sum : pz_sum;
  assign mpz_abs = evt_i.minus_pz[MOM_W-1] ? -{evt_i.minus_pz[MOM_W-1], evt_i.minus_pz}
                                           : {evt_i.minus_pz[MOM_W-1], evt_i.minus_pz};
  assign ppz_abs = evt_i.plus_pz[MOM_W-1] ? -{evt_i.plus_pz[MOM_W-1], evt_i.plus_pz}
                                          : {evt_i.plus_pz[MOM_W-1], evt_i.plus_pz};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pz_neg_q <= pz_sum[OPW-1];
      s1_q     <= evt_i.minus_pz[MOM_W-1];
      s2_q     <= evt_i.plus_pz[MOM_W-1];
      ids_ok_q <= (evt_i.first_id < ID_LIMIT) && (evt_i.second_id < ID_LIMIT);
    end
  end

  // multipliers: E^2, px^2, py^2, pz^2, |mpz|*pe, me*|ppz|; unit 0 later a*b
  assign mul0_start     = accept || (state_q == ST_SQRT && !sqa_busy && !sqb_busy && sel_now);
  assign mul_rest_start = accept;

  assign mul_a[0] = (state_q == ST_SQRT) ? OPW'(root_a) : e_sum;
  assign mul_b[0] = (state_q == ST_SQRT) ? OPW'(root_b) : e_sum;
  assign mul_a[1] = px_abs;
  assign mul_b[1] = px_abs;
  assign mul_a[2] = py_abs;
  assign mul_b[2] = py_abs;
  assign mul_a[3] = pz_abs;
  assign mul_b[3] = pz_abs;
  assign mul_a[4] = mpz_abs;
  assign mul_b[4] = OPW'(evt_i.plus_energy);
  assign mul_a[5] = OPW'(evt_i.minus_energy);
  assign mul_b[5] = ppz_abs;

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    dcta_mul #(.W(OPW)) u_mul (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(i == 0 ? mul0_start : mul_rest_start),
      .a_i    (mul_a[i]),
      .b_i    (mul_b[i]),
      .prod_o (prod[i]),
      .busy_o (mul_busy[i])
    );
  end

  assign sp1  = s1_q ? -{1'b0, prod[4][47:0]} : {1'b0, prod[4][47:0]};
  assign sp2  = s2_q ? -{1'b0, prod[5][47:0]} : {1'b0, prod[5][47:0]};
  assign m2   = t_q - qt2_q;
  assign dmag = d_q[48] ? 48'(-d_q) : d_q[47:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL && mul_busy == '0) begin
      t_q   <= {1'b0, prod[0]} - {1'b0, prod[3]};
      qt2_q <= {1'b0, prod[1]} + {1'b0, prod[2]};
      d_q   <= sp1 - sp2;
    end
    if (state_q == ST_M2) begin
      m2_neg_q <= m2[2*OPW];
      mag_q    <= {dmag[46:0], 1'b0};
      d_pos_q  <= !d_q[48] && (d_q != '0);
    end
  end

  // square roots of M2 and M2 + qt2
  assign sq_start = (state_q == ST_M2);

  dcta_sqrt #(.W(ROOTW)) u_sqa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (m2[2*OPW] ? '0 : m2[2*ROOTW-1:0]),
    .root_o (root_a),
    .busy_o (sqa_busy)
  );

  dcta_sqrt #(.W(ROOTW)) u_sqb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (t_q[2*ROOTW-1:0]),
    .root_o (root_b),
    .busy_o (sqb_busy)
  );

  assign sel_now = !m2_neg_q && ids_ok_q
                && (root_a >= {1'b0, mass_low_q}) && (root_a <= {1'b0, mass_high_q});

  // quotient
  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SQRT: begin
        if (!sqa_busy && !sqb_busy) begin
          sel_q  <= sel_now;
          mass_q <= m2_neg_q ? '0 : root_a;
          q_q    <= '0;
        end
      end
      ST_DEN: begin
        if (!mul_busy[0]) begin
          den_q     <= prod[0][47:0];
          rem_q     <= mag_q;
          div_cnt_q <= 4'(QW);
          if (prod[0][47:0] == '0) begin
            q_q <= '0;
          end else if (mag_q >= prod[0][47:0]) begin
            q_q <= COS_MAX;
          end
        end
      end
      ST_DIV: begin
        rem_q     <= rem_ge ? 48'(rem2 - {1'b0, den_q}) : rem2[47:0];
        q_q       <= {q_q[QW-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL:  if (mul_busy == '0) state_d = ST_M2;
      ST_M2:   state_d = ST_SQRT;
      ST_SQRT: begin
        if (!sqa_busy && !sqb_busy) state_d = sel_now ? ST_DEN : ST_DONE;
      end
      ST_DEN: begin
        if (!mul_busy[0]) begin
          if (prod[0][47:0] == '0 || mag_q >= prod[0][47:0]) state_d = ST_DONE;
          else state_d = ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt_q == 4'd1) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // result and totals
  assign neg     = d_pos_q ^ pz_neg_q;
  assign cos_val = !sel_q ? '0 : (neg ? -{1'b0, q_q} : {1'b0, q_q});
  assign fwd     = sel_q && !(neg && q_q != '0);
  assign out_load = (state_q == ST_DONE) && (!ov_q || res_o.ready);

  always_comb begin
    sel_cnt_d = sel_cnt_q;
    fwd_cnt_d = fwd_cnt_q;
    bwd_cnt_d = bwd_cnt_q;
    if (sel_q) begin
      if (!(&sel_cnt_q)) sel_cnt_d = sel_cnt_q + 1'b1;
      if (fwd) begin
        if (!(&fwd_cnt_q)) fwd_cnt_d = fwd_cnt_q + 1'b1;
      end else begin
        if (!(&bwd_cnt_q)) bwd_cnt_d = bwd_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_cnt_q <= '0;
      fwd_cnt_q <= '0;
      bwd_cnt_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (out_load) begin
        sel_cnt_q <= sel_cnt_d;
        fwd_cnt_q <= fwd_cnt_d;
        bwd_cnt_q <= bwd_cnt_d;
        ov_q      <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_sel_q  <= sel_q;
      o_fwd_q  <= fwd;
      o_mass_q <= mass_q[ROOTW-1] ? '1 : mass_q[MASS_W-1:0];
      o_cos_q  <= cos_val;
      o_st_q   <= TOT_W'(sel_cnt_d);
      o_ft_q   <= TOT_W'(fwd_cnt_d);
      o_bt_q   <= TOT_W'(bwd_cnt_d);
    end
  end

  assign res_o.valid          = ov_q;
  assign res_o.selected       = o_sel_q;
  assign res_o.pair_mass      = o_mass_q;
  assign res_o.cos_theta      = o_cos_q;
  assign res_o.forward        = o_fwd_q;
  assign res_o.selected_total = o_st_q;
  assign res_o.forward_total  = o_ft_q;
  assign res_o.backward_total = o_bt_q;

  a_fwd_needs_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && o_fwd_q |-> o_sel_q)
    else $error("forward beat without selection");

  a_cos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !o_sel_q |-> o_cos_q == '0)
    else $error("cosine nonzero on rejected event");

  a_sel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && sel_q |=> (sel_cnt_q == $past(sel_cnt_q) + 1'b1) || (&sel_cnt_q))
    else $error("selected counter did not advance");

  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_busy[0] |-> (state_q == ST_MUL) || (state_q == ST_DEN))
    else $error("multiplier running outside its phase");

endmodule
`default_nettype wire
